// ===== hdl/wsd_pkg.sv =====
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants for the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned OPC_W   = 4;
  localparam int unsigned LEN_W   = 63;
  localparam int unsigned EXT_W   = 4;
  localparam int unsigned SHORT_W = 7;

  localparam logic [SHORT_W-1:0] LEN_EXT16 = 7'd126;
  localparam logic [SHORT_W-1:0] LEN_EXT64 = 7'd127;
  localparam logic [EXT_W-1:0]   EXT16_BYTES = 4'd2;
  localparam logic [EXT_W-1:0]   EXT64_BYTES = 4'd8;

  localparam logic [OPC_W-1:0] OP_TEXT   = 4'h1;
  localparam logic [OPC_W-1:0] OP_BINARY = 4'h2;
  localparam logic [OPC_W-1:0] OP_CLOSE  = 4'h8;

  typedef enum logic [KIND_W-1:0] {
    KIND_BYTE  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_CLOSE = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXT     = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_SKIP    = 3'd4
  } phase_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] data_byte;
    logic [OPC_W-1:0]  frame_opcode;
    logic              last_in_frame;
    logic [LEN_W-1:0]  frame_length;
  } result_t;

endpackage

// ===== hdl/wsd_if.sv =====
// ----------------------------------------------------------------------------
// wsd_in_if / wsd_out_if
// Valid/ready channels for received bytes and for deframed results.
// ----------------------------------------------------------------------------
interface wsd_in_if;
  logic                      valid;
  logic                      ready;
  logic [wsd_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wsd_out_if;
  logic                       valid;
  logic                       ready;
  logic [wsd_pkg::KIND_W-1:0] kind;
  logic [wsd_pkg::BYTE_W-1:0] data_byte;
  logic [wsd_pkg::OPC_W-1:0]  frame_opcode;
  logic                       last_in_frame;
  logic [wsd_pkg::LEN_W-1:0]  frame_length;

  modport source (output valid, output kind, output data_byte, output frame_opcode,
                  output last_in_frame, output frame_length, input ready);
  modport sink   (input valid, input kind, input data_byte, input frame_opcode,
                  input last_in_frame, input frame_length, output ready);
endinterface

// ===== hdl/wsd_core.sv =====
// ----------------------------------------------------------------------------
// wsd_core
// Frame parser state and the per-byte step that updates it.
// ----------------------------------------------------------------------------
module wsd_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step_en,
  input  logic [wsd_pkg::BYTE_W-1:0]  rx_byte,
  output logic                        res_valid,
  output wsd_pkg::result_t            res
);

  wsd_pkg::phase_t              phase_r, phase_nxt;
  logic [wsd_pkg::OPC_W-1:0]    opcode_r, opcode_nxt;
  logic [wsd_pkg::LEN_W-1:0]    length_r, length_nxt;
  logic [wsd_pkg::EXT_W-1:0]    ext_left_r, ext_left_nxt;
  logic [wsd_pkg::LEN_W-1:0]    pay_left_r, pay_left_nxt;
  logic                         closed_r, closed_nxt;

  logic [wsd_pkg::SHORT_W-1:0]  short_len;
  logic [wsd_pkg::LEN_W-1:0]    ext_len;
  logic [wsd_pkg::EXT_W-1:0]    ext_dec;
  logic [wsd_pkg::LEN_W-1:0]    pay_dec;
  logic                         is_data;
  logic                         is_close;
  logic                         hdr_done;

  assign short_len = rx_byte[wsd_pkg::SHORT_W-1:0];
  assign ext_len   = {length_r[wsd_pkg::LEN_W-wsd_pkg::BYTE_W-1:0], rx_byte};
  assign ext_dec   = (ext_left_r != '0) ? ext_left_r - 1'b1 : ext_left_r;
  assign pay_dec   = pay_left_r - 1'b1;
  assign is_data   = (opcode_r == wsd_pkg::OP_TEXT) || (opcode_r == wsd_pkg::OP_BINARY);
  assign is_close  = (opcode_r == wsd_pkg::OP_CLOSE);

  // The header is complete once the length is fully known.
  always_comb begin
    hdr_done   = 1'b0;
    length_nxt = length_r;
    case (phase_r)
      wsd_pkg::PH_HDR1: begin
        if (short_len == wsd_pkg::LEN_EXT16 || short_len == wsd_pkg::LEN_EXT64) begin
          length_nxt = '0;
        end else begin
          length_nxt = {{(wsd_pkg::LEN_W-wsd_pkg::SHORT_W){1'b0}}, short_len};
          hdr_done   = 1'b1;
        end
      end
      wsd_pkg::PH_EXT: begin
        length_nxt = ext_len;
        hdr_done   = (ext_dec == '0);
      end
      default: begin
        hdr_done = 1'b0;
      end
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      wsd_pkg::PH_HDR1, wsd_pkg::PH_EXT: begin
        if (phase_r == wsd_pkg::PH_HDR1 && !hdr_done) begin
          phase_nxt = wsd_pkg::PH_EXT;
        end else if (hdr_done) begin
          if (length_nxt == '0) begin
            phase_nxt = wsd_pkg::PH_HDR0;
          end else if (is_data) begin
            phase_nxt = wsd_pkg::PH_PAYLOAD;
          end else begin
            phase_nxt = wsd_pkg::PH_SKIP;
          end
        end
      end
      wsd_pkg::PH_PAYLOAD, wsd_pkg::PH_SKIP: begin
        if (pay_dec == '0) begin
          phase_nxt = wsd_pkg::PH_HDR0;
        end
      end
      default: begin
        phase_nxt = wsd_pkg::PH_HDR1;
      end
    endcase
  end

  always_comb begin
    opcode_nxt        = opcode_r;
    ext_left_nxt      = ext_left_r;
    pay_left_nxt      = pay_left_r;
    closed_nxt        = closed_r;
    res_valid         = 1'b0;
    res.kind          = wsd_pkg::KIND_BYTE;
    res.data_byte     = '0;
    res.frame_opcode  = opcode_r;
    res.last_in_frame = 1'b1;
    res.frame_length  = length_nxt;
    if (hdr_done) begin
      pay_left_nxt = length_nxt;
    end
    case (phase_r)
      wsd_pkg::PH_HDR1: begin
        if (short_len == wsd_pkg::LEN_EXT16) begin
          ext_left_nxt = wsd_pkg::EXT16_BYTES;
        end else if (short_len == wsd_pkg::LEN_EXT64) begin
          ext_left_nxt = wsd_pkg::EXT64_BYTES;
        end
      end
      wsd_pkg::PH_EXT: begin
        ext_left_nxt = ext_dec;
      end
      wsd_pkg::PH_PAYLOAD: begin
        pay_left_nxt      = pay_dec;
        res_valid         = 1'b1;
        res.data_byte     = rx_byte;
        res.last_in_frame = (pay_dec == '0);
      end
      wsd_pkg::PH_SKIP: begin
        pay_left_nxt = pay_dec;
        if (pay_dec == '0 && is_close) begin
          closed_nxt = 1'b1;
          res_valid  = 1'b1;
          res.kind   = wsd_pkg::KIND_CLOSE;
        end
      end
      default: begin
        opcode_nxt = rx_byte[wsd_pkg::OPC_W-1:0];
      end
    endcase
    if (hdr_done && length_nxt == '0) begin
      if (is_close) begin
        closed_nxt = 1'b1;
        res_valid  = 1'b1;
        res.kind   = wsd_pkg::KIND_CLOSE;
      end else if (is_data) begin
        res_valid = 1'b1;
        res.kind  = wsd_pkg::KIND_EMPTY;
      end
    end
    if (closed_r) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= wsd_pkg::PH_HDR0;
      opcode_r   <= '0;
      length_r   <= '0;
      ext_left_r <= '0;
      pay_left_r <= '0;
      closed_r   <= 1'b0;
    end else if (step_en && !closed_r) begin
      phase_r    <= (closed_nxt) ? wsd_pkg::PH_HDR0 : phase_nxt;
      opcode_r   <= opcode_nxt;
      length_r   <= length_nxt;
      ext_left_r <= ext_left_nxt;
      pay_left_r <= pay_left_nxt;
      closed_r   <= closed_nxt;
    end
  end

endmodule

// ===== hdl/websocket_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Receive-side parser for unmasked WebSocket frames, one byte per request.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock while the result channel does
// not stall, and gives at most one result per byte: each payload byte of a
// text or binary frame, one marker for an empty data frame, and one close
// result at the end of a close frame, after which all input is dropped until
// reset. A byte passes an input register and then a result register before
// its result is offered, and the per-byte header and length update between
// them sets the sustained rate of one byte per cycle while not stalled.
module websocket_frame_deframer (
  input  logic             clk,
  input  logic             rst_n,
  wsd_in_if.sink           in_chan,
  wsd_out_if.source        out_chan
);

  logic                        in_valid_r;
  logic [wsd_pkg::BYTE_W-1:0]  in_byte_r;
  logic                        out_valid_r;
  wsd_pkg::result_t            out_res_r;
  logic                        advance;
  logic                        res_valid;
  wsd_pkg::result_t            res;

  assign advance       = !out_valid_r || out_chan.ready;
  assign in_chan.ready = !in_valid_r || advance;

  wsd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (in_valid_r && advance),
    .rx_byte   (in_byte_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= in_valid_r && res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_byte_r <= in_chan.rx_byte;
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.kind          = out_res_r.kind;
  assign out_chan.data_byte     = out_res_r.data_byte;
  assign out_chan.frame_opcode  = out_res_r.frame_opcode;
  assign out_chan.last_in_frame = out_res_r.last_in_frame;
  assign out_chan.frame_length  = out_res_r.frame_length;

endmodule

// ===== hdl/wsd_checker.sv =====
// ----------------------------------------------------------------------------
// wsd_checker
// Port-level checks on the deframer's result channel.
// ----------------------------------------------------------------------------
module wsd_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [wsd_pkg::KIND_W-1:0]  kind,
  input  logic [wsd_pkg::BYTE_W-1:0]  data_byte,
  input  logic [wsd_pkg::OPC_W-1:0]   frame_opcode,
  input  logic                        last_in_frame,
  input  logic [wsd_pkg::LEN_W-1:0]   frame_length
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(data_byte)
      && $stable(frame_opcode) && $stable(last_in_frame) && $stable(frame_length))
    else $error("stalled result changed");

  a_marker_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind != wsd_pkg::KIND_BYTE |-> last_in_frame && data_byte == '0
      && (kind == wsd_pkg::KIND_EMPTY || kind == wsd_pkg::KIND_CLOSE))
    else $error("malformed marker result");

  a_close_opcode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind == wsd_pkg::KIND_CLOSE |-> frame_opcode == wsd_pkg::OP_CLOSE)
    else $error("close result without close opcode");

  a_data_opcode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (kind == wsd_pkg::KIND_BYTE || kind == wsd_pkg::KIND_EMPTY) |->
      frame_opcode == wsd_pkg::OP_TEXT || frame_opcode == wsd_pkg::OP_BINARY)
    else $error("data result from a non-data frame");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .kind          (out_chan.kind),
  .data_byte     (out_chan.data_byte),
  .frame_opcode  (out_chan.frame_opcode),
  .last_in_frame (out_chan.last_in_frame),
  .frame_length  (out_chan.frame_length)
);
